@@ src/wfo_pkg.sv @@
`default_nettype none

package wfo_pkg;

    localparam int unsigned WAVE_BITS      = 2;
    localparam int unsigned STEP_BITS      = 32;
    localparam int unsigned CFG_INDEX_BITS = 4;
    localparam int unsigned SAMPLE_BITS    = 16;
    localparam int unsigned MAG_BITS       = 15;
    localparam int unsigned LFSR_BITS      = 32;

    typedef logic [WAVE_BITS-1:0]      t_wave;
    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;
    typedef logic [STEP_BITS-1:0]      t_step;
    typedef logic [MAG_BITS-1:0]       t_mag;
    typedef logic [LFSR_BITS-1:0]      t_lfsr;

    localparam t_wave WAVE_SINE   = 2'd0;
    localparam t_wave WAVE_SQUARE = 2'd1;
    localparam t_wave WAVE_SAW    = 2'd2;
    localparam t_wave WAVE_NOISE  = 2'd3;

    localparam t_cfg_index REG_WAVEFORM   = 4'd0;
    localparam t_cfg_index REG_PHASE_STEP = 4'd1;

    localparam t_wave WAVE_RESET = WAVE_SINE;
    localparam t_step STEP_RESET = 32'd42852281;
    localparam t_lfsr LFSR_SEED  = 32'h0000_0001;
    localparam t_lfsr LFSR_MASK  = 32'h8020_0003;

    localparam t_mag AMP = 15'd32760;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint SC1     = 64'sd1686629713;
    localparam longint SC3     = -64'sd693598668;
    localparam longint SC5     = 64'sd85569306;
    localparam longint SC7     = -64'sd5026995;
    localparam longint SC9     = 64'sd172272;

    // a * b / 2^30 truncated toward zero, b non-negative
    function automatic longint mul_q30(longint a, longint b);
        longint mag;
        mag = (a < 0) ? -a : a;
        mag = (mag * b) >>> 30;
        return (a < 0) ? -mag : mag;
    endfunction

    // quarter-wave entry k of a table with 2^table_bits steps per quadrant
    function automatic longint sine_entry(int k, int table_bits);
        longint x;
        longint x2;
        longint y;
        longint s;
        x  = longint'(k) <<< (30 - table_bits);
        x2 = mul_q30(x, x);
        y  = SC9;
        y  = SC7 + mul_q30(y, x2);
        y  = SC5 + mul_q30(y, x2);
        y  = SC3 + mul_q30(y, x2);
        y  = SC1 + mul_q30(y, x2);
        s  = mul_q30(y, x);
        if (s < 0) begin
            s = 0;
        end
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return (s * longint'(AMP) + (Q30_ONE >>> 1)) >>> 30;
    endfunction

endpackage

`default_nettype wire

@@ src/waveform_oscillator_core.sv @@
// waveform_oscillator_core: direct digital synthesis audio oscillator
//
// input channel (i_in_valid / o_in_ready, i_restart): one transaction per
// sample tick; restart high clears the phase to zero before that sample
// output channel (o_out_valid / i_out_ready, o_sample): one signed sample
// per input transaction, in order
// config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
// index 0 waveform (0 sine, 1 square, 2 saw, 3 noise), index 1 phase step;
// other indexes are ignored; o_cfg_ready is always high; write only while idle
// latency: o_out_valid rises 2 cycles after the edge that takes the input
// transaction (input register, sine rom read register, output register)
// throughput: one transaction per cycle, set by the single-cycle phase
// accumulator and lfsr update at the input stage
// reset: phase 0, lfsr 1, sine waveform, step for 440 Hz at 44.1 kHz,
// pipeline emptied
// receiver stall: o_sample holds, up to three transactions stay in flight,
// then o_in_ready drops until the receiver takes a sample
`default_nettype none

module waveform_oscillator_core #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_restart,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [15:0]           o_sample,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire wfo_pkg::t_cfg_index     i_cfg_index,
    input  wire wfo_pkg::t_step          i_cfg_data
);
    import wfo_pkg::*;

    localparam int TB = SINE_TABLE_BITS;
    localparam int PB = PHASE_BITS;

    localparam logic [PB-1:0] PHASE_HALF = {1'b1, {(PB-1){1'b0}}};
    localparam logic [TB:0]   SINE_Q     = {1'b1, {TB{1'b0}}};

    t_wave r_waveform;
    t_step r_phase_step;

    logic [PB-1:0] r_phase;
    t_lfsr         r_lfsr;

    logic          r_s1_valid;
    logic [PB-1:0] r_s1_phase;
    logic [15:0]   r_s1_noise;

    logic          r_s2_valid;
    logic [PB-1:0] r_s2_e;
    logic          r_s2_upper;
    logic [15:0]   r_s2_noise_mag;
    logic          r_s2_noise_neg;

    logic          r_out_valid;
    logic [15:0]   r_out_sample;

    logic en_out;
    logic en_s2;
    logic en_s1;
    logic in_accept;

    logic [PB-1:0] n_p;
    t_lfsr         n_lfsr;
    logic [TB-1:0] k;
    logic [TB:0]   rom_addr;
    t_mag          sine_mag;

    logic [PB+14:0] saw_prod;
    t_mag           saw_mag;
    logic [30:0]    noise_prod;
    t_mag           noise_mag;
    logic [15:0]    n_sample;

    // pipeline flow
    assign en_out     = !r_out_valid || i_out_ready;
    assign en_s2      = !r_s2_valid || en_out;
    assign en_s1      = !r_s1_valid || en_s2;
    assign o_in_ready = en_s1;
    assign in_accept  = i_in_valid && en_s1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform   <= WAVE_RESET;
            r_phase_step <= STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WAVEFORM:   r_waveform   <= i_cfg_data[WAVE_BITS-1:0];
                REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input stage: phase accumulator and noise lfsr
    always_comb begin
        n_p    = i_restart ? '0 : r_phase;
        n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_lfsr     <= LFSR_SEED;
            r_s1_valid <= 1'b0;
        end else begin
            if (en_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (in_accept) begin
                r_phase <= n_p + PB'(r_phase_step);
                r_lfsr  <= n_lfsr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_phase <= n_p;
            r_s1_noise <= n_lfsr[31:16];
        end
    end

    // second stage: rom read, saw distance, noise magnitude
    assign k        = r_s1_phase[PB-3 -: TB];
    assign rom_addr = r_s1_phase[PB-2] ? (SINE_Q - {1'b0, k}) : {1'b0, k};

    wfo_sine_rom #(
        .TABLE_BITS (TB)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (en_s2),
        .i_addr (rom_addr),
        .o_data (sine_mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s2_upper     <= r_s1_phase[PB-1];
            r_s2_e         <= r_s1_phase[PB-1] ? (r_s1_phase - PHASE_HALF)
                                               : (PHASE_HALF - r_s1_phase);
            r_s2_noise_neg <= r_s1_noise[15];
            r_s2_noise_mag <= r_s1_noise[15] ? (16'd0 - r_s1_noise) : r_s1_noise;
        end
    end

    // output stage: scale and select
    always_comb begin
        // x * 32760 as x * 32768 - x * 8
        saw_prod   = {r_s2_e, 15'd0} - {12'd0, r_s2_e, 3'd0};
        saw_mag    = saw_prod[PB+13:PB-1];
        noise_prod = {r_s2_noise_mag, 15'd0} - {12'd0, r_s2_noise_mag, 3'd0};
        noise_mag  = noise_prod[29:15];
        unique case (r_waveform)
            WAVE_SINE: begin
                n_sample = r_s2_upper ? (16'd0 - {1'b0, sine_mag}) : {1'b0, sine_mag};
            end
            WAVE_SQUARE: begin
                n_sample = r_s2_upper ? (16'd0 - {1'b0, AMP}) : {1'b0, AMP};
            end
            WAVE_SAW: begin
                n_sample = r_s2_upper ? {1'b0, saw_mag} : (16'd0 - {1'b0, saw_mag});
            end
            WAVE_NOISE: begin
                n_sample = r_s2_noise_neg ? (16'd0 - {1'b0, noise_mag})
                                          : {1'b0, noise_mag};
            end
            default: begin
                n_sample = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_sample <= n_sample;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = $signed(r_out_sample);

endmodule

`default_nettype wire

@@ src/wfo_sine_rom.sv @@
`default_nettype none

module wfo_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [TABLE_BITS:0]   i_addr,
    output wfo_pkg::t_mag              o_data
);
    import wfo_pkg::*;

    localparam int DEPTH = (1 << TABLE_BITS) + 1;

    typedef t_mag t_rom [0:DEPTH-1];

    function automatic t_rom build_rom();
        t_rom tbl;
        for (int k = 0; k < DEPTH; k++) begin
            tbl[k] = MAG_BITS'(sine_entry(k, TABLE_BITS));
        end
        return tbl;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    t_mag r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

@@ src/wfo_checker.sv @@
`default_nettype none

module wfo_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [15:0] o_sample
);

    // a pending output transaction stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_sample))
        else $error("sample changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample >= -16'sd32760) && (o_sample <= 16'sd32760))
        else $error("sample out of range");

    // input backpressure only comes from a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

endmodule

bind waveform_oscillator_core wfo_checker u_wfo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_sample    (o_sample)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    import wfo_pkg::*;

    localparam int          PHASE_W           = 32;
    localparam int          TABLE_BITS        = 10;
    localparam int          TABLE_TOP         = 1 << TABLE_BITS;
    localparam int          FULL_SCALE        = 32760;
    localparam logic [31:0] NOISE_TAPS        = 32'h8020_0003;
    localparam longint      HALF_CYCLE        = 64'sd2147483648;
    localparam longint      Q30_UNIT          = 64'sd1073741824;
    localparam longint      Q30_HALF          = 64'sd536870912;
    localparam longint      TAYLOR_C1         = 64'sd1686629713;
    localparam longint      TAYLOR_C3         = -64'sd693598668;
    localparam longint      TAYLOR_C5         = 64'sd85569306;
    localparam longint      TAYLOR_C7         = -64'sd5026995;
    localparam longint      TAYLOR_C9         = 64'sd172272;
    localparam t_step       QUARTER_TURN      = 32'h4000_0000;
    localparam t_step       HALF_TURN         = 32'h8000_0000;
    localparam t_step       FULL_STEP         = 32'hFFFF_FFFF;
    localparam int unsigned AUDIO_STEP_PER_HZ = 97392;
    localparam t_cfg_index  REG_SPARE_LO      = 4'd2;
    localparam t_cfg_index  REG_SPARE_HI      = 4'd15;
    localparam int          SETTLE_CYCLES     = 6;
    localparam int          SEGMENTS          = 21;
    localparam int          SEGMENT_ITEMS     = 83;
    localparam int          RESTART_PCT       = 5;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_restart  = 1'b0;
    logic              out_ready   = 1'b0;
    logic              cfg_valid   = 1'b0;
    t_cfg_index        cfg_index   = REG_WAVEFORM;
    t_step             cfg_data    = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic signed [15:0] o_sample;
    logic              o_cfg_ready;

    logic               pending_restarts[$];
    logic signed [15:0] expected_samples[$];
    int                 send_idle_pct = 17;
    int                 recv_idle_pct = 55;
    int                 mismatch_count = 0;

    // oscillator state as the block should hold it
    logic [31:0] osc_phase;
    logic [31:0] noise_lfsr;
    t_wave       cur_wave;
    t_step       cur_step;
    int          sine_rom [0:TABLE_TOP];

    waveform_oscillator_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (in_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_sample    (o_sample),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint scale_q30(longint a, longint b);
        if (a < 0) begin
            return -(((-a) * b) >>> 30);
        end
        return (a * b) >>> 30;
    endfunction

    function automatic int quarter_sine_level(int k);
        longint coef [0:4];
        longint x;
        longint x2;
        longint y;
        longint s;
        coef = '{TAYLOR_C9, TAYLOR_C7, TAYLOR_C5, TAYLOR_C3, TAYLOR_C1};
        x  = longint'(k) << (30 - TABLE_BITS);
        x2 = scale_q30(x, x);
        y  = coef[0];
        for (int i = 1; i < 5; i++) begin
            y = coef[i] + scale_q30(y, x2);
        end
        s = scale_q30(y, x);
        if (s < 0) begin
            s = 0;
        end else if (s > Q30_UNIT) begin
            s = Q30_UNIT;
        end
        return int'((s * FULL_SCALE + Q30_HALF) >>> 30);
    endfunction

    function automatic logic signed [15:0] predict_sample(input logic restart);
        logic [31:0]        p;
        longint             pl;
        int                 k;
        logic signed [15:0] r;
        longint             mag;
        logic signed [15:0] noise_val;
        logic signed [15:0] level;
        if (restart) begin
            osc_phase = '0;
        end
        p  = osc_phase;
        pl = longint'(p);
        // lfsr advances on every tick whatever the waveform
        noise_lfsr = noise_lfsr[0] ? ((noise_lfsr >> 1) ^ NOISE_TAPS) : (noise_lfsr >> 1);
        r          = noise_lfsr[31:16];
        mag        = (r < 0) ? -longint'(r) : longint'(r);
        mag        = (mag * FULL_SCALE) >>> 15;
        noise_val  = 16'((r < 0) ? -mag : mag);
        case (cur_wave)
            WAVE_SINE: begin
                k = int'(p[PHASE_W-3 -: TABLE_BITS]);
                if (p[PHASE_W-2]) begin
                    k = TABLE_TOP - k;
                end
                level = 16'(p[PHASE_W-1] ? -sine_rom[k] : sine_rom[k]);
            end
            WAVE_SQUARE: begin
                level = 16'(p[PHASE_W-1] ? -FULL_SCALE : FULL_SCALE);
            end
            WAVE_SAW: begin
                if (p[PHASE_W-1]) begin
                    level = 16'(((pl - HALF_CYCLE) * 2 * FULL_SCALE) >>> PHASE_W);
                end else begin
                    level = 16'(-(((HALF_CYCLE - pl) * 2 * FULL_SCALE) >>> PHASE_W));
                end
            end
            default: begin
                level = noise_val;
            end
        endcase
        osc_phase = p + cur_step;
        return level;
    endfunction

    function automatic t_step pick_step();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return HALF_TURN;
                    3:       return FULL_STEP;
                    default: return STEP_RESET;
                endcase
            end
            1, 2: return t_step'($urandom_range(1, 22050) * AUDIO_STEP_PER_HZ);
            default: return $urandom();
        endcase
    endfunction

    // input side: one transaction per pending restart flag
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_samples.push_back(predict_sample(in_restart));
            end
            if (!in_valid || o_in_ready) begin
                if (pending_restarts.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid   <= 1'b1;
                    in_restart <= pending_restarts.pop_front();
                end else begin
                    in_valid   <= 1'b0;
                    in_restart <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    // output side
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_samples.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: sample expected none, got %0d", $time, o_sample);
                end else if (o_sample !== expected_samples[0]) begin
                    mismatch_count++;
                    $display("%0t: sample expected %0d, got %0d", $time,
                             expected_samples[0], o_sample);
                    void'(expected_samples.pop_front());
                end else begin
                    void'(expected_samples.pop_front());
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic wait_for_drain();
        do begin
            @(posedge clk);
        end while (pending_restarts.size() != 0 || in_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input t_step data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge clk);
        end while (!o_cfg_ready);
        case (idx)
            REG_WAVEFORM:   cur_wave = data[1:0];
            REG_PHASE_STEP: cur_step = data;
            default: ;
        endcase
    endtask

    task automatic load_setting(input t_wave wave, input t_step step, input bit with_spare);
        t_step wave_data;
        wave_data      = $urandom();
        wave_data[1:0] = wave;
        wait_for_drain();
        if (with_spare) begin
            write_register(t_cfg_index'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
        end
        if ($urandom_range(0, 1)) begin
            write_register(REG_WAVEFORM, wave_data);
            write_register(REG_PHASE_STEP, step);
        end else begin
            write_register(REG_PHASE_STEP, step);
            write_register(REG_WAVEFORM, wave_data);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pattern(input logic [7:0] pattern, input int count);
        for (int i = 0; i < count; i++) begin
            pending_restarts.push_back(pattern[i]);
        end
    endtask

    initial begin
        osc_phase  = '0;
        noise_lfsr = LFSR_SEED;
        cur_wave   = WAVE_RESET;
        cur_step   = STEP_RESET;
        for (int k = 0; k <= TABLE_TOP; k++) begin
            sine_rom[k] = quarter_sine_level(k);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, restart late in the run
        queue_pattern(8'b100, 3);
        // quarter steps land on every quadrant boundary
        load_setting(WAVE_SINE, QUARTER_TURN, 1'b0);
        queue_pattern(8'b1, 5);
        load_setting(WAVE_SQUARE, HALF_TURN, 1'b0);
        queue_pattern(8'b1, 3);
        // step beyond half a cycle wraps the phase
        load_setting(WAVE_SAW, FULL_STEP, 1'b0);
        queue_pattern(8'b1, 3);
        load_setting(WAVE_SAW, HALF_TURN, 1'b1);
        queue_pattern(8'b1, 2);
        load_setting(WAVE_NOISE, STEP_RESET, 1'b0);
        queue_pattern(8'b0, 4);
        load_setting(WAVE_SINE, '0, 1'b1);
        queue_pattern(8'b11, 2);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                send_idle_pct = 55;
                recv_idle_pct = 17;
            end else if (seg == 2 * SEGMENTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_setting(t_wave'($urandom_range(0, 3)), pick_step(), $urandom_range(0, 3) == 0);
            for (int i = 0; i < SEGMENT_ITEMS; i++) begin
                pending_restarts.push_back($urandom_range(0, 99) < RESTART_PCT);
            end
        end

        wait_for_drain();
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("[waveform_oscillator_core] OK");
        end else begin
            $display("[waveform_oscillator_core] ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("[waveform_oscillator_core] ERROR");
        $finish;
    end

endmodule
